@@ rtl/core/pla_pkg.sv @@
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types and constants of the paged linear allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pla_pkg;

  // Field widths of the request and response channels
  localparam int unsigned SIZE_W  = 25;
  localparam int unsigned ALIGN_W = 5;
  localparam int unsigned OFFS_W  = 24;
  localparam int unsigned PIDX_W  = 4;
  localparam int unsigned PCNT_W  = 5;

  // Alignment math runs wide enough for 2^31 alignments plus the carry
  localparam int unsigned WIDE_W = 33;

  // Register port
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = 25'd2097152;

  // Request modes
  localparam logic MODE_ALLOC  = 1'b0;
  localparam logic MODE_REWIND = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_NO_PAGES = 2'd3
  } status_e;

  typedef struct packed {
    logic               mode;
    logic [SIZE_W-1:0]  size_bytes;
    logic [ALIGN_W-1:0] align_log2;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PIDX_W-1:0] page_index;
    logic [OFFS_W-1:0] byte_offset;
    logic              new_page;
    logic [PCNT_W-1:0] pages_in_pool;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/pla_if.sv @@
// ----------------------------------------------------------------------------
// pla_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface pla_req_if;
  import pla_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [SIZE_W-1:0]  size_bytes;
  logic [ALIGN_W-1:0] align_log2;

  modport source (output valid, mode, size_bytes, align_log2, input ready);
  modport sink   (input valid, mode, size_bytes, align_log2, output ready);
endinterface

interface pla_rsp_if;
  import pla_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PIDX_W-1:0] page_index;
  logic [OFFS_W-1:0] byte_offset;
  logic              new_page;
  logic [PCNT_W-1:0] pages_in_pool;

  modport source (output valid, status, page_index, byte_offset, new_page, pages_in_pool,
                  input ready);
  modport sink   (input valid, status, page_index, byte_offset, new_page, pages_in_pool,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/pla_core.sv @@
// ----------------------------------------------------------------------------
// pla_core
// Allocator state and the single-pass align / fit / page-switch decision.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_core #(
  parameter int unsigned MAX_PAGES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire pla_pkg::req_t         req_i,
  input  wire logic [pla_pkg::SIZE_W-1:0] page_size_i,
  output pla_pkg::rsp_t              rsp_o
);
  import pla_pkg::*;

  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAGES);

  logic          have_q, have_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [SIZE_W-1:0] fill_q, fill_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [WIDE_W-1:0] mask, asize, aoff, blk_end, psize_w;
  logic [CW-1:0]     next_pg;
  logic              too_big, need_switch, need_new, exhausted, no_fit;

  // Alignment, fit check and page-switch decision
  always_comb begin
    mask     = (WIDE_W'(1) << req_i.align_log2) - WIDE_W'(1);
    asize    = (WIDE_W'(req_i.size_bytes) + mask) & ~mask;
    aoff     = (WIDE_W'(fill_q) + mask) & ~mask;
    blk_end  = aoff + asize;
    psize_w  = WIDE_W'(page_size_i);
    too_big  = req_i.size_bytes > page_size_i;
    need_switch = !have_q || (blk_end > psize_w);
    next_pg  = have_q ? (CW'(cur_q) + CW'(1)) : '0;
    need_new = next_pg >= cnt_q;
    exhausted = need_new && (cnt_q >= CNT_MAX);
    no_fit   = asize > psize_w;
  end

  // Next state and response
  always_comb begin
    have_d = have_q;
    cur_d  = cur_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    rsp_o.status        = ST_OK;
    rsp_o.page_index    = PIDX_W'(cur_q);
    rsp_o.byte_offset   = '0;
    rsp_o.new_page      = 1'b0;
    rsp_o.pages_in_pool = PCNT_W'(cnt_q);

    if (req_i.mode == MODE_REWIND) begin
      have_d = 1'b0;
      cur_d  = '0;
      fill_d = '0;
      rsp_o.page_index = '0;
    end else if (too_big) begin
      rsp_o.status = ST_TOO_BIG;
    end else if (need_switch && exhausted) begin
      rsp_o.status = ST_NO_PAGES;
    end else if (need_switch) begin
      // move to the next page, creating it when the pool has none spare
      have_d = 1'b1;
      cur_d  = PW'(next_pg);
      if (need_new) cnt_d = cnt_q + CW'(1);
      rsp_o.page_index    = PIDX_W'(next_pg);
      rsp_o.new_page      = 1'b1;
      rsp_o.pages_in_pool = need_new ? PCNT_W'(cnt_q + CW'(1)) : PCNT_W'(cnt_q);
      if (no_fit) begin
        fill_d = '0;
        rsp_o.status = ST_NO_FIT;
      end else begin
        fill_d = asize[SIZE_W-1:0];
      end
    end else begin
      fill_d = blk_end[SIZE_W-1:0];
      rsp_o.byte_offset = aoff[OFFS_W-1:0];
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      cur_q  <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      have_q <= have_d;
      cur_q  <= cur_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/paged_linear_allocator.sv @@
// ----------------------------------------------------------------------------
// paged_linear_allocator
// Paged bump allocator: aligned allocations from a pool of equal pages.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transaction: mode 0 allocates size_bytes
//   aligned to 2^align_log2, mode 1 rewinds to the first page of the pool.
//   rsp_o returns exactly one response per request, in order: status,
//   page_index, aligned byte_offset, new_page and pages_in_pool.
//   page_size is set through the APB port at byte address 0; write it only
//   while no request is in flight.
// Pipeline and throughput:
//   A request goes into an input register, is decided in one pass of
//   align, add and compare logic against the allocator state, and lands in
//   the response register, which drives rsp valid. One request per cycle is
//   sustained while rsp_o is not stalled; the allocator state is updated
//   once per request at the same edge the response is registered.
// Reset and stall:
//   Reset empties the pool, drops the current page and sets page_size to
//   2 MiB. While rsp_o is stalled one more request is held in the input
//   register; after that req_i.ready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_linear_allocator #(
  parameter int unsigned MAX_PAGES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pla_req_if.sink                          req_i,
  pla_rsp_if.source                        rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pla_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pla_pkg::DATA_W-1:0]  pwdata,
  output logic      [pla_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pla_pkg::*;

  logic [SIZE_W-1:0] page_size_q;
  logic              in_valid_q;
  req_t              in_req_q;
  logic              out_valid_q;
  rsp_t              out_rsp_q;
  rsp_t              core_rsp;
  logic              advance;
  logic              reg_hit;

  // Register file: one register, page_size
  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1:2] == REG_PAGE_SIZE;
  assign prdata  = reg_hit ? DATA_W'(page_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      page_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // Pipeline control
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q.mode       <= req_i.mode;
      in_req_q.size_bytes <= req_i.size_bytes;
      in_req_q.align_log2 <= req_i.align_log2;
    end
  end

  pla_core #(
    .MAX_PAGES (MAX_PAGES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_i       (in_req_q),
    .page_size_i (page_size_q),
    .rsp_o       (core_rsp)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_rsp_q <= core_rsp;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_rsp_q.status;
  assign rsp_o.page_index    = out_rsp_q.page_index;
  assign rsp_o.byte_offset   = out_rsp_q.byte_offset;
  assign rsp_o.new_page      = out_rsp_q.new_page;
  assign rsp_o.pages_in_pool = out_rsp_q.pages_in_pool;

endmodule

`default_nettype wire

@@ rtl/core/pla_checker.sv @@
// ----------------------------------------------------------------------------
// pla_checker
// Port-level checks of the allocator responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pla_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [1:0]                  rsp_status,
  input wire logic [pla_pkg::PIDX_W-1:0]  rsp_page,
  input wire logic [pla_pkg::OFFS_W-1:0]  rsp_offset,
  input wire logic                        rsp_new_page,
  input wire logic [pla_pkg::PCNT_W-1:0]  rsp_pool
);
  import pla_pkg::*;

  logic [PIDX_W-1:0] last_page_q;
  logic [PCNT_W-1:0] last_pool_q;

  // Track the last delivered page and pool size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_page_q <= '0;
      last_pool_q <= '0;
    end else if (rsp_valid && rsp_ready) begin
      last_page_q <= rsp_page;
      last_pool_q <= rsp_pool;
    end
  end

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_page) && $stable(rsp_offset)
      && $stable(rsp_status))
    else $error("stalled response changed");

  // Only a successful allocation reports a nonzero offset
  a_offset_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_offset != '0) |-> (rsp_status == ST_OK) && !rsp_new_page)
    else $error("offset reported on a failed or new-page response");

  // Pages are never released
  a_pool_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_pool >= last_pool_q)
    else $error("pool size went down");

  // Without a page switch the allocation stays on the current page
  // (a rewind answers on page 0, so page 0 is left out)
  a_same_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == ST_OK) && !rsp_new_page && (rsp_page != '0)
      |-> rsp_page == last_page_q)
    else $error("page changed without a page switch");

endmodule

bind paged_linear_allocator pla_checker u_pla_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_status   (rsp_o.status),
  .rsp_page     (rsp_o.page_index),
  .rsp_offset   (rsp_o.byte_offset),
  .rsp_new_page (rsp_o.new_page),
  .rsp_pool     (rsp_o.pages_in_pool)
);

`default_nettype wire

@@ verif/tb_paged_linear_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_paged_linear_allocator
// Self-checking bench for the paged bump allocator. A table of directed
// requests hits the page-size extremes, every status and the rewind path,
// then random requests run under several page sizes with bursty input and
// a stalling response side. Each response is compared field by field with
// the table's expected value or a bench-side model of the allocator state.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_paged_linear_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import pla_pkg::*;

  localparam int unsigned MAX_PAGES    = 16;
  localparam int unsigned DIR_ROWS     = 18;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned SQUEEZE_AT   = 20;
  localparam int unsigned SQUEEZE_LEN  = 100;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS  = 20;
  localparam int unsigned EXP_DEPTH    = 64;

  typedef enum logic [1:0] {
    PAT_OPEN,
    PAT_SPARSE,
    PAT_EVERY3,
    PAT_COIN
  } stall_pat_e;

  // One directed row: optional page_size write, then reps identical requests
  typedef struct {
    bit                 set_cfg;
    logic [SIZE_W-1:0]  cfg_val;
    logic               mode;
    logic [SIZE_W-1:0]  size_bytes;
    logic [ALIGN_W-1:0] align_log2;
    int unsigned        reps;
    bit                 typed;
    rsp_t               want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pla_req_if req_bus ();
  pla_rsp_if rsp_bus ();

  paged_linear_allocator #(
    .MAX_PAGES(MAX_PAGES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Allocator state as the bench tracks it
  logic [SIZE_W-1:0] page_bytes;
  bit                have_page;
  logic [PIDX_W-1:0] cur_page;
  logic [SIZE_W-1:0] fill_bytes;
  int unsigned       pool_pages;

  // Expected responses in request order
  rsp_t        exp_mem[EXP_DEPTH];
  logic [5:0]  exp_wr;
  logic [5:0]  exp_rd;
  int unsigned exp_cnt;

  dir_row_t    dir_tbl[DIR_ROWS];
  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned rsp_count;
  int unsigned status_seen[4];
  int unsigned burst_left;
  bit          squeeze_go;

  function automatic void exp_put(input rsp_t r);
    exp_mem[exp_wr] = r;
    exp_wr++;
    exp_cnt++;
  endfunction

  function automatic rsp_t exp_take();
    rsp_t r;
    r = exp_mem[exp_rd];
    exp_rd++;
    exp_cnt--;
    return r;
  endfunction

  // Predict one response and advance the bump state
  function automatic rsp_t bump_predict(input req_t rq);
    rsp_t              r;
    longint unsigned   step;
    longint unsigned   asize;
    longint unsigned   aoff;
    longint unsigned   limit;
    int unsigned       nxt;
    r       = '0;
    r.status = ST_OK;
    r.pages_in_pool = PCNT_W'(pool_pages);
    if (rq.mode == MODE_REWIND) begin
      have_page  = 1'b0;
      cur_page   = '0;
      fill_bytes = '0;
      return r;
    end
    limit = longint'(page_bytes);
    if (longint'(rq.size_bytes) > limit) begin
      r.status     = ST_TOO_BIG;
      r.page_index = cur_page;
      return r;
    end
    step  = 64'd1 << rq.align_log2;
    asize = (longint'(rq.size_bytes) + step - 1) & ~(step - 1);
    aoff  = (longint'(fill_bytes) + step - 1) & ~(step - 1);
    if (!have_page || aoff + asize > limit) begin
      nxt = have_page ? int'(cur_page) + 1 : 0;
      if (nxt >= pool_pages) begin
        if (pool_pages >= MAX_PAGES) begin
          r.status     = ST_NO_PAGES;
          r.page_index = cur_page;
          return r;
        end
        pool_pages++;
        r.pages_in_pool = PCNT_W'(pool_pages);
      end
      have_page  = 1'b1;
      cur_page   = PIDX_W'(nxt);
      fill_bytes = '0;
      aoff       = 0;
      r.new_page = 1'b1;
      if (asize > limit) begin
        r.status     = ST_NO_FIT;
        r.page_index = cur_page;
        return r;
      end
    end
    fill_bytes    = SIZE_W'(aoff + asize);
    r.page_index  = cur_page;
    r.byte_offset = OFFS_W'(aoff);
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Random request, shaped around the current page size
  function automatic req_t draw_request();
    req_t        rq;
    int unsigned pick;
    int unsigned trim;
    pick          = $urandom_range(0, 99);
    rq.mode       = MODE_ALLOC;
    rq.size_bytes = SIZE_W'($urandom);
    rq.align_log2 = ALIGN_W'($urandom_range(0, 31));
    if (pick < 6) begin
      rq.mode = MODE_REWIND;
    end else if (pick < 14) begin
      // raw noise over the whole field range
    end else if (pick < 24) begin
      trim          = $urandom_range(0, 2);
      rq.size_bytes = (trim > page_bytes) ? '0 : page_bytes - SIZE_W'(trim);
      rq.align_log2 = ALIGN_W'($urandom_range(0, 3));
    end else begin
      rq.size_bytes = SIZE_W'($urandom_range(0, int'(page_bytes) / 8));
      if ($urandom_range(0, 9) == 0)
        rq.align_log2 = ALIGN_W'($urandom_range(9, 24));
      else
        rq.align_log2 = ALIGN_W'($urandom_range(0, 8));
    end
    return rq;
  endfunction

  // Offer one request in bursts with random gaps; queue its expected response
  task automatic offer(input req_t rq, input bit typed, input rsp_t want);
    rsp_t        pred;
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk_i);
        req_bus.valid      = 1'b0;
        req_bus.mode       = 1'($urandom);
        req_bus.size_bytes = SIZE_W'($urandom);
        req_bus.align_log2 = ALIGN_W'($urandom);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_bus.valid      = 1'b1;
    req_bus.mode       = rq.mode;
    req_bus.size_bytes = rq.size_bytes;
    req_bus.align_log2 = rq.align_log2;
    do @(posedge clk_i); while (!req_bus.ready);
    pred = bump_predict(rq);
    exp_put(typed ? want : pred);
    sent_count++;
  endtask

  // Let every outstanding response drain before touching the register
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (exp_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of page_size, then read it back
  task automatic set_page_size(input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_PAGE_SIZE, 2'b00};
    pwdata  = DATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    page_bytes = value;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("page_size readback", DATA_W'(value), prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Response side: own stall pattern, one long hold-off, field checks
  initial begin
    int unsigned rx_cyc;
    int unsigned hold_left;
    bit          held;
    stall_pat_e  pat;
    rsp_t        want;
    rx_cyc    = 0;
    hold_left = 0;
    held      = 1'b0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze_go && !held) begin
        held      = 1'b1;
        hold_left = SQUEEZE_LEN;
      end
      pat = stall_pat_e'((rx_cyc / 40) % 4);
      if (hold_left != 0) begin
        rsp_bus.ready = 1'b0;
        hold_left--;
      end else begin
        case (pat)
          PAT_OPEN:   rsp_bus.ready = 1'b1;
          PAT_SPARSE: rsp_bus.ready = ($urandom_range(0, 3) != 0);
          PAT_EVERY3: rsp_bus.ready = (rx_cyc % 3 != 0);
          default:    rsp_bus.ready = 1'($urandom);
        endcase
      end
      rx_cyc++;
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_count++;
        status_seen[rsp_bus.status]++;
        if (exp_cnt == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: response with no request pending, expected none, actual 0x%0h",
                     $time, {rsp_bus.status, rsp_bus.page_index, rsp_bus.byte_offset,
                             rsp_bus.new_page, rsp_bus.pages_in_pool});
        end else begin
          want = exp_take();
          check_field("status", want.status, rsp_bus.status);
          check_field("page_index", want.page_index, rsp_bus.page_index);
          check_field("byte_offset", want.byte_offset, rsp_bus.byte_offset);
          check_field("new_page", want.new_page, rsp_bus.new_page);
          check_field("pages_in_pool", want.pages_in_pool, rsp_bus.pages_in_pool);
        end
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned run_cycles;
    run_cycles = 0;
    while (run_cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      run_cycles++;
    end
    $display("%0t ns: watchdog expired with %0d responses pending", $time, exp_cnt);
    $display("paged_linear_allocator verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    req_t        rq;
    logic [SIZE_W-1:0] psz;
    rsp_t        none;
    none        = '0;
    fail_count  = 0;
    sent_count  = 0;
    rsp_count   = 0;
    status_seen = '{default: 0};
    burst_left  = 0;
    squeeze_go  = 1'b0;
    exp_wr      = '0;
    exp_rd      = '0;
    exp_cnt     = 0;

    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.mode       = MODE_ALLOC;
    req_bus.size_bytes = '0;
    req_bus.align_log2 = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;

    page_bytes = PAGE_SIZE_RST;
    have_page  = 1'b0;
    cur_page   = '0;
    fill_bytes = '0;
    pool_pages = 0;

    // Directed table: first allocation, oversize, alignments up to 2^31,
    // no-fit after a kept page switch, rewind and reuse, offset wrap at a
    // 16 MiB page end, pool exhaustion with 1-byte pages
    dir_tbl[0]  = '{0, 0, MODE_ALLOC, 25'd0, 5'd0, 1, 1, '{ST_OK, 4'd0, 24'd0, 1'b1, 5'd1}};
    dir_tbl[1]  = '{0, 0, MODE_ALLOC, 25'h200001, 5'd0, 1, 1,
                    '{ST_TOO_BIG, 4'd0, 24'd0, 1'b0, 5'd1}};
    dir_tbl[2]  = '{0, 0, MODE_ALLOC, 25'd100, 5'd4, 1, 0, none};
    dir_tbl[3]  = '{0, 0, MODE_ALLOC, 25'd2097152, 5'd0, 1, 0, none};
    dir_tbl[4]  = '{0, 0, MODE_ALLOC, 25'h1FFFFFF, 5'd31, 1, 1,
                    '{ST_TOO_BIG, 4'd1, 24'd0, 1'b0, 5'd2}};
    dir_tbl[5]  = '{0, 0, MODE_ALLOC, 25'd5, 5'd31, 1, 1,
                    '{ST_NO_FIT, 4'd2, 24'd0, 1'b1, 5'd3}};
    dir_tbl[6]  = '{0, 0, MODE_ALLOC, 25'd7, 5'd17, 1, 0, none};
    dir_tbl[7]  = '{0, 0, MODE_REWIND, 25'h1555555, 5'h15, 1, 1,
                    '{ST_OK, 4'd0, 24'd0, 1'b0, 5'd3}};
    dir_tbl[8]  = '{0, 0, MODE_ALLOC, 25'd1, 5'd0, 1, 0, none};
    dir_tbl[9]  = '{1, 25'd16777216, MODE_ALLOC, 25'd16777216, 5'd0, 1, 0, none};
    dir_tbl[10] = '{0, 0, MODE_ALLOC, 25'd0, 5'd0, 1, 1, '{ST_OK, 4'd1, 24'd0, 1'b0, 5'd3}};
    dir_tbl[11] = '{0, 0, MODE_ALLOC, 25'd16777216, 5'd24, 1, 0, none};
    dir_tbl[12] = '{1, 25'd1, MODE_REWIND, 25'd0, 5'd0, 1, 1,
                    '{ST_OK, 4'd0, 24'd0, 1'b0, 5'd3}};
    dir_tbl[13] = '{0, 0, MODE_ALLOC, 25'd1, 5'd0, 16, 0, none};
    dir_tbl[14] = '{0, 0, MODE_ALLOC, 25'd1, 5'd0, 1, 1,
                    '{ST_NO_PAGES, 4'd15, 24'd0, 1'b0, 5'd16}};
    dir_tbl[15] = '{0, 0, MODE_ALLOC, 25'd0, 5'd0, 1, 0, none};
    dir_tbl[16] = '{0, 0, MODE_ALLOC, 25'd2, 5'd3, 1, 1,
                    '{ST_TOO_BIG, 4'd15, 24'd0, 1'b0, 5'd16}};
    dir_tbl[17] = '{0, 0, MODE_REWIND, 25'd0, 5'd0, 1, 1,
                    '{ST_OK, 4'd0, 24'd0, 1'b0, 5'd16}};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].set_cfg) begin
        drain();
        set_page_size(dir_tbl[i].cfg_val);
      end
      rq.mode       = dir_tbl[i].mode;
      rq.size_bytes = dir_tbl[i].size_bytes;
      rq.align_log2 = dir_tbl[i].align_log2;
      repeat (dir_tbl[i].reps) offer(rq, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Random phases, each under its own page size
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       psz = 25'd1;
        1:       psz = 25'd16777216;
        2:       psz = SIZE_W'($urandom_range(16, 4096));
        3:       psz = PAGE_SIZE_RST;
        default: psz = SIZE_W'($urandom_range(1, 16777216));
      endcase
      drain();
      set_page_size(psz);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Response side holds off here while requests keep coming
        if (ph == 2 && n == SQUEEZE_AT) squeeze_go = 1'b1;
        offer(draw_request(), 1'b0, none);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests with %0d responses checked (ok %0d, too big %0d, no fit %0d,",
             sent_count, rsp_count, status_seen[ST_OK], status_seen[ST_TOO_BIG],
             status_seen[ST_NO_FIT]);
    $display("out of pages %0d) over page sizes 1 B to 16 MiB and alignments to 2^31.",
             status_seen[ST_NO_PAGES]);
    if (fail_count == 0) begin
      $display("paged_linear_allocator verification clean");
    end else begin
      $display("paged_linear_allocator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
